// File: design/mbwm_pkg.sv
package mbwm_pkg;

  localparam int MAX_BUCKETS_DEF = 64;

  localparam int MINUTE_W = 27;
  localparam int BUCKET_W = 48;
  localparam int NOW_W    = 32;
  localparam int BYTES_W  = 40;
  localparam int WINDOW_W = 17;
  localparam int SUM_W    = 54;
  localparam int RETAIN_W = 12;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_METER_ENABLED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RETENTION     = 1'd1;

  localparam logic [RETAIN_W-1:0] RETENTION_RESET = 12'd600;

  // reciprocal of 60: floor(now * MAGIC / 2^37) is exact for every 32-bit now
  localparam logic [31:0] DIV60_MAGIC = 32'h8888_8889;
  localparam int          DIV60_SHIFT = 37;

  localparam int QUEUE_DEPTH = 2;
  localparam int QAW         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_ACCOUNT,
    KIND_QUERY
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [MINUTE_W-1:0] minute;
    logic [NOW_W-1:0]    limit;
    logic [BYTES_W-1:0]  bytes;
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic [QCW-1:0]   count;
  } q_status_t;

  typedef struct packed {
    logic [MINUTE_W-1:0] minute;
    logic [BUCKET_W-1:0] bytes;
  } bucket_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC_RD,
    ST_ACC_CK,
    ST_DROP_RD,
    ST_DROP_CK,
    ST_QUERY
  } back_state_e;

endpackage

// File: design/mbwm_front.sv
module mbwm_front
  import mbwm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  op_i,
  input  logic [NOW_W-1:0]      now_seconds_i,
  input  logic [BYTES_W-1:0]    byte_count_i,
  input  logic [WINDOW_W-1:0]   window_seconds_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  q_status_t             q_status_i,
  output logic                  push_o,
  output cmd_t                  push_cmd_o
);

  logic                 enabled_q;
  logic [RETAIN_W-1:0]  retention_q;

  logic                 s1_valid_q;
  logic                 s1_op_q;
  logic [NOW_W-1:0]     s1_now_q;
  logic [BYTES_W-1:0]   s1_bytes_q;
  logic [WINDOW_W-1:0]  s1_win_q;

  logic                 accept;
  logic [63:0]          product;
  logic [NOW_W-1:0]     span;
  logic [QCW:0]         in_flight;

  assign cfg_ready_o = 1'b1;

  // count the beat in the classify stage so the queue never overflows
  assign in_flight = {1'b0, q_status_i.count} + (QCW+1)'(s1_valid_q);
  assign busy      = (in_flight >= (QCW+1)'(QUEUE_DEPTH));
  assign accept    = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= 1'b1;
      retention_q <= RETENTION_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_METER_ENABLED: enabled_q   <= cfg_data_i[0];
        REG_RETENTION:     retention_q <= cfg_data_i[RETAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q    <= op_i;
      s1_now_q   <= now_seconds_i;
      s1_bytes_q <= byte_count_i;
      s1_win_q   <= window_seconds_i;
    end
  end

  always_comb begin
    product = 64'(s1_now_q) * 64'(DIV60_MAGIC);
    if (s1_op_q) begin
      span = NOW_W'(s1_win_q);
    end else begin
      span = NOW_W'(retention_q);
    end

    push_o            = s1_valid_q;
    push_cmd_o.minute = product[DIV60_SHIFT +: MINUTE_W];
    push_cmd_o.bytes  = s1_bytes_q;
    // start of the kept span, clamped at time zero
    push_cmd_o.limit  = (s1_now_q >= span) ? (s1_now_q - span) : '0;
    if (s1_op_q) begin
      push_cmd_o.kind = KIND_QUERY;
    end else if (enabled_q) begin
      push_cmd_o.kind = KIND_ACCOUNT;
    end else begin
      push_cmd_o.kind = KIND_NOP;
    end
  end

endmodule

// File: design/mbwm_queue.sv
module mbwm_queue
  import mbwm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cmd_t      push_cmd_i,
  input  logic      pop_i,
  output cmd_t      head_o,
  output q_status_t status_o
);

  cmd_t           slots_q [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_q;
  logic [QAW-1:0] rd_ptr_q;
  logic [QCW-1:0] count_q;

  function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
    logic [QAW-1:0] r;
    if (p == QAW'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + QAW'(1);
    end
    return r;
  endfunction

  assign head_o         = slots_q[rd_ptr_q];
  assign status_o.valid = (count_q != '0);
  assign status_o.count = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_cmd_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < QCW'(QUEUE_DEPTH)))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue pop while empty");
`endif

endmodule

// File: design/mbwm_back.sv
module mbwm_back
  import mbwm_pkg::*;
#(
  parameter int MAX_BUCKETS = MAX_BUCKETS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  q_status_t        q_status_i,
  input  cmd_t             q_head_i,
  output logic             pop_o,
  output logic             result_valid_o,
  output logic [SUM_W-1:0] window_bytes_o
);

  localparam int AW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int CW = $clog2(MAX_BUCKETS + 1);

  bucket_t ring_mem [MAX_BUCKETS];
  bucket_t rd_data_q;

  back_state_e      state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [AW-1:0]    oldest_q, oldest_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    k_q, k_d;
  logic             rdv_q, rdv_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             res_valid_q, res_valid_d;
  logic [SUM_W-1:0] res_bytes_q, res_bytes_d;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  bucket_t       wr_data;

  logic            do_open;
  logic            full;
  logic [AW-1:0]   newest_slot;
  logic [AW-1:0]   open_slot;
  logic [AW-1:0]   oldest_inc;
  logic [32:0]     rd_start;
  logic            rd_too_old;
  logic [BUCKET_W:0] acc_sum;
  logic [SUM_W:0]    win_sum;

  // ring position base + k, with base + k below twice the ring size
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(k);
    if (s >= (CW+1)'(MAX_BUCKETS)) begin
      s = s - (CW+1)'(MAX_BUCKETS);
    end
    return s[AW-1:0];
  endfunction

  always_comb begin
    full        = (count_q == CW'(MAX_BUCKETS));
    newest_slot = slot_of(oldest_q, count_q - CW'(1));
    open_slot   = full ? oldest_q : slot_of(oldest_q, count_q);
    oldest_inc  = slot_of(oldest_q, CW'(1));
    // minute start in seconds: minute * 64 - minute * 4
    rd_start    = {rd_data_q.minute, 6'b0} - {4'b0, rd_data_q.minute, 2'b0};
    rd_too_old  = (rd_start < {1'b0, cmd_q.limit});
    acc_sum     = {1'b0, rd_data_q.bytes} + (BUCKET_W+1)'(cmd_q.bytes);
    win_sum     = {1'b0, sum_q} + (SUM_W+1)'(rd_data_q.bytes);
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    oldest_d    = oldest_q;
    count_d     = count_q;
    k_d         = k_q;
    rdv_d       = 1'b0;
    sum_d       = sum_q;
    res_valid_d = 1'b0;
    res_bytes_d = res_bytes_q;
    pop_o       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = rd_data_q;
    do_open     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_status_i.valid) begin
          pop_o = 1'b1;
          cmd_d = q_head_i;
          unique case (q_head_i.kind)
            KIND_NOP: begin
              res_valid_d = 1'b1;
              res_bytes_d = '0;
            end
            KIND_ACCOUNT: begin
              state_d = ST_ACC_RD;
            end
            KIND_QUERY: begin
              state_d = ST_QUERY;
              k_d     = count_q;
              sum_d   = '0;
            end
            default: ;
          endcase
        end
      end
      ST_ACC_RD: begin
        if (count_q == '0) begin
          do_open = 1'b1;
          state_d = ST_DROP_RD;
        end else begin
          rd_en   = 1'b1;
          rd_addr = newest_slot;
          state_d = ST_ACC_CK;
        end
      end
      ST_ACC_CK: begin
        if (rd_data_q.minute == cmd_q.minute) begin
          wr_en           = 1'b1;
          wr_addr         = newest_slot;
          wr_data.minute  = rd_data_q.minute;
          wr_data.bytes   = acc_sum[BUCKET_W] ? '1 : acc_sum[BUCKET_W-1:0];
        end else begin
          do_open = 1'b1;
        end
        state_d = ST_DROP_RD;
      end
      ST_DROP_RD: begin
        if (count_q == '0) begin
          res_valid_d = 1'b1;
          res_bytes_d = '0;
          state_d     = ST_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = oldest_q;
          state_d = ST_DROP_CK;
        end
      end
      ST_DROP_CK: begin
        if (rd_too_old) begin
          oldest_d = oldest_inc;
          count_d  = count_q - CW'(1);
          state_d  = ST_DROP_RD;
        end else begin
          res_valid_d = 1'b1;
          res_bytes_d = '0;
          state_d     = ST_IDLE;
        end
      end
      ST_QUERY: begin
        // reads go out one per cycle, each checked the cycle after
        if ((rdv_q && rd_too_old) || (!rdv_q && k_q == '0)) begin
          res_valid_d = 1'b1;
          res_bytes_d = sum_q;
          state_d     = ST_IDLE;
        end else begin
          if (rdv_q) begin
            sum_d = win_sum[SUM_W] ? '1 : win_sum[SUM_W-1:0];
          end
          if (k_q != '0) begin
            rd_en   = 1'b1;
            rd_addr = slot_of(oldest_q, k_q - CW'(1));
            k_d     = k_q - CW'(1);
            rdv_d   = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (do_open) begin
      wr_en          = 1'b1;
      wr_addr        = open_slot;
      wr_data.minute = cmd_q.minute;
      wr_data.bytes  = BUCKET_W'(cmd_q.bytes);
      if (full) begin
        oldest_d = oldest_inc;
      end else begin
        count_d = count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      oldest_q    <= '0;
      count_q     <= '0;
      k_q         <= '0;
      rdv_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      oldest_q    <= oldest_d;
      count_q     <= count_d;
      k_q         <= k_d;
      rdv_q       <= rdv_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    sum_q       <= sum_d;
    res_bytes_q <= res_bytes_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= ring_mem[rd_addr];
    end
  end

  assign result_valid_o = res_valid_q;
  assign window_bytes_o = res_bytes_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_BUCKETS))
    else $error("bucket count above ring size");

  a_oldest_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oldest_q < AW'(MAX_BUCKETS) || MAX_BUCKETS == (1 << AW))
    else $error("oldest slot outside ring");

  a_write_in_account: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == ST_ACC_RD || state_q == ST_ACC_CK))
    else $error("ring written outside account");
`endif

endmodule

// File: design/minute_bucket_io_window_meter.sv
// an account adds to the newest bucket or opens a new one, then drops buckets older than
// the retention one at a time; a query sums buckets from the newest back until one is older
// than the window; a disabled account skips the ring and returns a zero result
// throughput: the ring sequencer works on one item at a time through its bucket memory,
// at most two items wait ahead of it; the receiver cannot stall the one-cycle strobe
// reset: ring empty, meter enabled, retention 600 s; the bucket memory is not cleared
module minute_bucket_io_window_meter
  import mbwm_pkg::*;
#(
  parameter int MAX_BUCKETS = MAX_BUCKETS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  op_i,
  input  logic [NOW_W-1:0]      now_seconds_i,
  input  logic [BYTES_W-1:0]    byte_count_i,
  input  logic [WINDOW_W-1:0]   window_seconds_i,
  output logic                  result_valid_o,
  output logic [SUM_W-1:0]      window_bytes_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  q_status_t q_status;
  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  cmd_t      q_head;

  mbwm_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .op_i             (op_i),
    .now_seconds_i    (now_seconds_i),
    .byte_count_i     (byte_count_i),
    .window_seconds_i (window_seconds_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .q_status_i       (q_status),
    .push_o           (push),
    .push_cmd_o       (push_cmd)
  );

  mbwm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (q_head),
    .status_o   (q_status)
  );

  mbwm_back #(
    .MAX_BUCKETS (MAX_BUCKETS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_status_i     (q_status),
    .q_head_i       (q_head),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .window_bytes_o (window_bytes_o)
  );

endmodule
